/* design/assert_macros.svh */
// Assertion helper macros shared by the RTL.
// Depends on a clk and an active-low arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/rfbh_pkg.sv */
// Types, constants and helper functions for the bind/hop receiver controller.
// No dependencies.
package rfbh_pkg;

	localparam int TX_ID_W   = 32;
	localparam int TIME_W    = 32;
	localparam int TIMEOUT_W = 16;
	localparam int CRC_W     = 16;
	localparam int MARKER_W  = 24;
	localparam int CSUM_W    = 8;
	localparam int CHAN_W    = 7;
	localparam int POS_W     = 7;
	localparam int CFG_IDX_W = 2;

	// Bind sweep range
	localparam logic [CHAN_W-1:0] BIND_FIRST_CHANNEL = 7'd6;
	localparam logic [CHAN_W-1:0] BIND_LAST_CHANNEL  = 7'd38;

	// Hop channel i = HOP_BASE + HOP_SPAN*i + (nibble sum mod 15)
	localparam logic [CHAN_W-1:0] HOP_BASE = 7'd6;
	localparam logic [CHAN_W-1:0] HOP_SPAN = 7'd15;

	localparam logic [MARKER_W-1:0] BIND_MARKER = 24'h000001;

	localparam logic [TIMEOUT_W-1:0] BIND_TIMEOUT_RST = 16'd1000;
	localparam logic [TIMEOUT_W-1:0] DATA_TIMEOUT_RST = 16'd5000;

	typedef enum logic [1:0] {
		STATUS_NONE = 2'd0,
		STATUS_BIND = 2'd1,
		STATUS_DATA = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STORED_TX_ID = 2'd0,
		CFG_BIND_TIMEOUT = 2'd1,
		CFG_DATA_TIMEOUT = 2'd2
	} cfg_index_t;

	// Hop channel for one slot from one ID byte
	function automatic logic [CHAN_W-1:0] hop_channel(input logic [1:0] slot,
			input logic [7:0] id_byte);
		logic [4:0] nib_sum;
		logic [3:0] nib_mod;
		logic [CHAN_W-1:0] base;
		nib_sum = {1'b0, id_byte[7:4]} + {1'b0, id_byte[3:0]};
		// nibble sum is at most 30: two conditional subtracts give mod 15
		if (nib_sum >= 5'd30)
			nib_mod = 4'(nib_sum - 5'd30);
		else if (nib_sum >= 5'd15)
			nib_mod = 4'(nib_sum - 5'd15);
		else
			nib_mod = nib_sum[3:0];
		base = HOP_BASE + HOP_SPAN * {5'd0, slot};
		return base + {3'd0, nib_mod};
	endfunction

	// Byte-wise checksum of the ID, mod 256
	function automatic logic [CSUM_W-1:0] id_byte_sum(input logic [TX_ID_W-1:0] id);
		return id[7:0] + id[15:8] + id[23:16] + id[31:24];
	endfunction

endpackage

/* design/rf_bind_hop_receiver.sv */
// Receiver link controller: bind detection, hop table and channel hopping.
// Depends on rfbh_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one poll or restart transaction
//   with the radio packet fields and the current microsecond time. Output
//   channel (out_valid / out_stall) returns exactly one result per input:
//   status, selected channel, channel-written flag, save flag and bound ID.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data): index 0
//   stored transmitter ID, 1 bind hop timeout, 2 data hop timeout; other
//   indexes are ignored. Write it only while no transaction is in flight.
// Flow and throughput:
//   A transaction accepted into the input register has its result registered
//   in the result register once that register is free, and out_valid rises.
//   One transaction per cycle is sustained while out_stall is low; link state is updated
//   in the same cycle the result is registered, so the next item sees it directly.
// Reset:
//   Bind phase on channel 6, hop table and times cleared, bound ID zero,
//   stored ID zero, timeouts 1000 us (bind) and 5000 us (data).
// Stall:
//   While out_stall holds a result, the input register holds too and in_stall
//   rises once it is full; at most two transactions are buffered.
`include "assert_macros.svh"

module rf_bind_hop_receiver #(
	parameter int HOP_CHANNELS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [rfbh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfbh_pkg::TX_ID_W-1:0]    cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic                            packet_present,
	input  logic [rfbh_pkg::CRC_W-1:0]      crc_computed,
	input  logic [rfbh_pkg::CRC_W-1:0]      crc_received,
	input  logic [rfbh_pkg::TX_ID_W-1:0]    packet_id_bytes,
	input  logic [rfbh_pkg::MARKER_W-1:0]   marker_bytes,
	input  logic [rfbh_pkg::CSUM_W-1:0]     id_checksum,
	input  logic [rfbh_pkg::TIME_W-1:0]     time_now_us,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [rfbh_pkg::CHAN_W-1:0]     rf_channel,
	output logic                            channel_set,
	output logic                            save_id,
	output logic [rfbh_pkg::TX_ID_W-1:0]    learned_tx_id
);
	import rfbh_pkg::*;

	// configuration registers
	logic [TX_ID_W-1:0]   stored_id_q;
	logic [TIMEOUT_W-1:0] bind_timeout_q;
	logic [TIMEOUT_W-1:0] data_timeout_q;

	// link state
	logic                 phase_q;
	logic [POS_W-1:0]     pos_q;
	logic [CHAN_W-1:0]    hop_q [HOP_CHANNELS];
	logic [TIME_W-1:0]    last_hop_q;
	logic [TX_ID_W-1:0]   bound_id_q;

	// input register
	logic                 valid_s1;
	logic                 func_s1;
	logic                 present_s1;
	logic [CRC_W-1:0]     crc_c_s1;
	logic [CRC_W-1:0]     crc_r_s1;
	logic [TX_ID_W-1:0]   id_s1;
	logic [MARKER_W-1:0]  marker_s1;
	logic [CSUM_W-1:0]    csum_s1;
	logic [TIME_W-1:0]    now_s1;

	// result register
	logic                 out_valid_q;
	status_t              status_q;
	logic [CHAN_W-1:0]    chan_q;
	logic                 set_q;
	logic                 save_q;
	logic [TX_ID_W-1:0]   learned_q;

	// step results
	logic                 adv_s1;
	logic                 good;
	logic                 bind_ok;
	logic                 load_hops;
	logic [TX_ID_W-1:0]   hop_src;
	logic                 phase_n;
	logic [POS_W-1:0]     pos_n;
	logic [TIME_W-1:0]    last_n;
	logic [TX_ID_W-1:0]   bound_n;
	logic [TX_ID_W-1:0]   stored_n;
	logic [TIMEOUT_W-1:0] timeout;
	logic [TIME_W-1:0]    deadline;
	logic [POS_W:0]       pos_inc;
	status_t              status_n;
	logic                 set_n;
	logic                 save_n;
	logic [CHAN_W-1:0]    hop_n [HOP_CHANNELS];
	logic [CHAN_W-1:0]    chan_n;

	// handshake: input register moves on when the result register is free
	assign adv_s1   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1    <= func;
			present_s1 <= packet_present;
			crc_c_s1   <= crc_computed;
			crc_r_s1   <= crc_received;
			id_s1      <= packet_id_bytes;
			marker_s1  <= marker_bytes;
			csum_s1    <= id_checksum;
			now_s1     <= time_now_us;
		end
	end

	// one step of the link controller
	always_comb begin
		good    = present_s1 && (crc_c_s1 == crc_r_s1);
		bind_ok = !phase_q && good && (marker_s1 == BIND_MARKER) &&
			(id_byte_sum(id_s1) == csum_s1);

		phase_n   = phase_q;
		pos_n     = pos_q;
		last_n    = last_hop_q;
		bound_n   = bound_id_q;
		stored_n  = stored_id_q;
		load_hops = 1'b0;
		hop_src   = id_s1;
		status_n  = STATUS_NONE;
		set_n     = 1'b0;
		save_n    = 1'b0;

		if (func_s1) begin
			// restart: data phase with the stored ID, else back to bind
			set_n  = 1'b1;
			last_n = now_s1;
			if (stored_id_q != '0) begin
				bound_n   = stored_id_q;
				phase_n   = 1'b1;
				pos_n     = '0;
				load_hops = 1'b1;
				hop_src   = stored_id_q;
			end else begin
				phase_n = 1'b0;
				pos_n   = BIND_FIRST_CHANNEL;
			end
		end else begin
			if (bind_ok) begin
				status_n  = STATUS_BIND;
				bound_n   = id_s1;
				if (stored_id_q == '0) begin
					stored_n = id_s1;
					save_n   = 1'b1;
				end
				phase_n   = 1'b1;
				pos_n     = '0;
				load_hops = 1'b1;
				last_n    = now_s1;
				set_n     = 1'b1;
			end else if (phase_q && good) begin
				status_n = STATUS_DATA;
			end

			// hop on data packet or timeout (wrapping deadline)
			timeout  = phase_n ? data_timeout_q : bind_timeout_q;
			deadline = last_n + TIME_W'(timeout);
			if (status_n == STATUS_DATA || now_s1 > deadline) begin
				pos_inc = {1'b0, pos_n} + 1'b1;
				if (!phase_n) begin
					if (pos_inc > {1'b0, BIND_LAST_CHANNEL})
						pos_n = BIND_FIRST_CHANNEL;
					else
						pos_n = pos_inc[POS_W-1:0];
				end else begin
					if (pos_inc >= (POS_W+1)'(HOP_CHANNELS))
						pos_n = '0;
					else
						pos_n = pos_inc[POS_W-1:0];
				end
				last_n = now_s1;
				set_n  = 1'b1;
			end
		end
		timeout  = phase_n ? data_timeout_q : bind_timeout_q;
		deadline = last_n + TIME_W'(timeout);
		pos_inc  = {1'b0, pos_n};
	end

	// hop table derivation and channel selection
	always_comb begin
		for (int i = 0; i < HOP_CHANNELS; i++) begin
			hop_n[i] = load_hops ? hop_channel(2'(i), hop_src[8*i +: 8]) : hop_q[i];
		end
		chan_n = '0;
		if (phase_n) begin
			for (int i = 0; i < HOP_CHANNELS; i++) begin
				if (pos_n[1:0] == 2'(i))
					chan_n = hop_n[i];
			end
		end else begin
			chan_n = pos_n;
		end
	end

	// link state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_id_q    <= '0;
			bind_timeout_q <= BIND_TIMEOUT_RST;
			data_timeout_q <= DATA_TIMEOUT_RST;
			phase_q        <= 1'b0;
			pos_q          <= BIND_FIRST_CHANNEL;
			last_hop_q     <= '0;
			bound_id_q     <= '0;
			for (int i = 0; i < HOP_CHANNELS; i++)
				hop_q[i] <= '0;
		end else begin
			if (valid_s1 && adv_s1) begin
				stored_id_q <= stored_n;
				phase_q     <= phase_n;
				pos_q       <= pos_n;
				last_hop_q  <= last_n;
				bound_id_q  <= bound_n;
				for (int i = 0; i < HOP_CHANNELS; i++)
					hop_q[i] <= hop_n[i];
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_STORED_TX_ID: stored_id_q    <= cfg_data;
					CFG_BIND_TIMEOUT: bind_timeout_q <= cfg_data[TIMEOUT_W-1:0];
					CFG_DATA_TIMEOUT: data_timeout_q <= cfg_data[TIMEOUT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			status_q  <= status_n;
			chan_q    <= chan_n;
			set_q     <= set_n;
			save_q    <= save_n;
			learned_q <= bound_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign rf_channel    = chan_q;
	assign channel_set   = set_q;
	assign save_id       = save_q;
	assign learned_tx_id = learned_q;

	// checks
	`ASSERT_IMPLY(a_data_sets_channel, out_valid_q && status_q == STATUS_DATA, set_q, "data packet without hop")
	`ASSERT_IMPLY(a_save_only_on_bind, out_valid_q && save_q, status_q == STATUS_BIND, "save flag outside bind")
	`ASSERT_IMPLY(a_bind_pos_range, !phase_q, pos_q >= BIND_FIRST_CHANNEL && pos_q <= BIND_LAST_CHANNEL, "bind position out of sweep")
	`ASSERT_IMPLY(a_data_pos_range, phase_q, pos_q < POS_W'(HOP_CHANNELS), "data position beyond hop table")
	`ASSERT_NEXT(a_commit_delivers, valid_s1 && adv_s1, out_valid_q, "committed step not presented")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for rf_bind_hop_receiver: directed and random poll/restart transactions,
// with every result checked against a predictor of the bind and hop logic.
// Depends on rfbh_pkg and the receiver RTL.
module testbench;
	import rfbh_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	localparam int HOP_SLOTS   = 4;
	localparam int PHASE_ITEMS = 200;
	// index past the register map, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd3;

	typedef struct {
		logic                func;
		logic                present;
		logic [CRC_W-1:0]    crc_c;
		logic [CRC_W-1:0]    crc_r;
		logic [TX_ID_W-1:0]  id;
		logic [MARKER_W-1:0] marker;
		logic [CSUM_W-1:0]   csum;
		logic [TIME_W-1:0]   now;
	} radio_poll_t;

	typedef struct {
		status_t            status;
		logic [CHAN_W-1:0]  chan;
		logic               chan_set;
		logic               save;
		logic [TX_ID_W-1:0] id;
	} link_report_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [TX_ID_W-1:0]    cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  func;
	logic                  packet_present;
	logic [CRC_W-1:0]      crc_computed;
	logic [CRC_W-1:0]      crc_received;
	logic [TX_ID_W-1:0]    packet_id_bytes;
	logic [MARKER_W-1:0]   marker_bytes;
	logic [CSUM_W-1:0]     id_checksum;
	logic [TIME_W-1:0]     time_now_us;
	logic                  out_valid;
	logic                  out_stall;
	logic [1:0]            status;
	logic [CHAN_W-1:0]     rf_channel;
	logic                  channel_set;
	logic                  save_id;
	logic [TX_ID_W-1:0]    learned_tx_id;

	// predicted link state and register copies
	logic [TX_ID_W-1:0]    lnk_stored_id;
	logic [TIMEOUT_W-1:0]  lnk_bind_to;
	logic [TIMEOUT_W-1:0]  lnk_data_to;
	logic                  lnk_bound_phase;
	logic [POS_W-1:0]      lnk_pos;
	logic [CHAN_W-1:0]     lnk_hops [HOP_SLOTS];
	logic [TIME_W-1:0]     lnk_last_hop;
	logic [TX_ID_W-1:0]    lnk_bound_id;

	link_report_t          expected_reports [$];
	link_report_t          want_report;
	int                    n_fail;
	int                    n_cycles;
	int                    sender_gap_pct;
	int                    receiver_stall_pct;
	logic [TIME_W-1:0]     clock_us;

	rf_bind_hop_receiver i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.packet_present  (packet_present),
		.crc_computed    (crc_computed),
		.crc_received    (crc_received),
		.packet_id_bytes (packet_id_bytes),
		.marker_bytes    (marker_bytes),
		.id_checksum     (id_checksum),
		.time_now_us     (time_now_us),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.rf_channel      (rf_channel),
		.channel_set     (channel_set),
		.save_id         (save_id),
		.learned_tx_id   (learned_tx_id)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [CSUM_W-1:0] id_sum8(input logic [TX_ID_W-1:0] id);
		return CSUM_W'(id[7:0] + id[15:8] + id[23:16] + id[31:24]);
	endfunction

	// enter the data phase: hop table from the ID bytes, slot 0
	function automatic void load_hop_table(input logic [TX_ID_W-1:0] id,
			input logic [TIME_W-1:0] t);
		int nib;
		lnk_bound_phase = 1'b1;
		lnk_last_hop = t;
		lnk_pos = '0;
		for (int i = 0; i < HOP_SLOTS; i++) begin
			nib = (int'(id[8*i+4 +: 4]) + int'(id[8*i +: 4])) % 15;
			lnk_hops[i] = CHAN_W'(int'(HOP_BASE) + int'(HOP_SPAN) * i + nib);
		end
	endfunction

	// advance the link state by one transaction and return its result
	function automatic link_report_t link_after_item(input radio_poll_t p);
		link_report_t r;
		logic good;
		logic [TIME_W-1:0] deadline;
		r.status = STATUS_NONE;
		r.chan_set = 1'b0;
		r.save = 1'b0;
		if (p.func) begin
			r.chan_set = 1'b1;
			lnk_last_hop = p.now;
			if (lnk_stored_id != '0) begin
				lnk_bound_id = lnk_stored_id;
				load_hop_table(lnk_stored_id, p.now);
			end else begin
				lnk_bound_phase = 1'b0;
				lnk_pos = BIND_FIRST_CHANNEL;
			end
		end else begin
			good = p.present && (p.crc_c == p.crc_r);
			if (!lnk_bound_phase) begin
				if (good && p.marker == BIND_MARKER && id_sum8(p.id) == p.csum) begin
					r.status = STATUS_BIND;
					r.chan_set = 1'b1;
					lnk_bound_id = p.id;
					if (lnk_stored_id == '0) begin
						lnk_stored_id = p.id;
						r.save = 1'b1;
					end
					load_hop_table(p.id, p.now);
				end
			end else if (good) begin
				r.status = STATUS_DATA;
			end
			// 32-bit wrapping deadline, timeout of the phase after binding
			deadline = lnk_last_hop + (lnk_bound_phase ? lnk_data_to : lnk_bind_to);
			if (r.status == STATUS_DATA || p.now > deadline) begin
				if (!lnk_bound_phase)
					lnk_pos = (lnk_pos >= BIND_LAST_CHANNEL) ? BIND_FIRST_CHANNEL
						: lnk_pos + 1'b1;
				else
					lnk_pos = (lnk_pos >= POS_W'(HOP_SLOTS - 1)) ? '0 : lnk_pos + 1'b1;
				lnk_last_hop = p.now;
				r.chan_set = 1'b1;
			end
		end
		r.chan = lnk_bound_phase ? lnk_hops[lnk_pos[1:0]] : lnk_pos[CHAN_W-1:0];
		r.id = lnk_bound_id;
		return r;
	endfunction

	// ---------------------------------------------------------------- item builders

	function automatic radio_poll_t noise_poll(input logic [TIME_W-1:0] t);
		radio_poll_t p;
		p.func = 1'b0;
		p.present = 1'($urandom_range(0, 1));
		p.crc_c = CRC_W'($urandom);
		p.crc_r = ($urandom_range(0, 3) == 0) ? p.crc_c : CRC_W'($urandom);
		p.id = $urandom;
		p.marker = MARKER_W'($urandom);
		p.csum = CSUM_W'($urandom);
		p.now = t;
		return p;
	endfunction

	function automatic radio_poll_t bind_packet(input logic [TX_ID_W-1:0] id,
			input logic [TIME_W-1:0] t);
		radio_poll_t p;
		p = noise_poll(t);
		p.present = 1'b1;
		p.crc_r = p.crc_c;
		p.id = id;
		p.marker = BIND_MARKER;
		p.csum = id_sum8(id);
		return p;
	endfunction

	function automatic radio_poll_t data_packet(input logic [TIME_W-1:0] t);
		radio_poll_t p;
		p = noise_poll(t);
		p.present = 1'b1;
		p.crc_r = p.crc_c;
		return p;
	endfunction

	function automatic radio_poll_t restart_item(input logic [TIME_W-1:0] t);
		radio_poll_t p;
		p = noise_poll(t);
		p.func = 1'b1;
		return p;
	endfunction

	function automatic radio_poll_t quiet_poll(input logic [TIME_W-1:0] t);
		radio_poll_t p;
		p = noise_poll(t);
		p.present = 1'b0;
		return p;
	endfunction

	// ---------------------------------------------------------------- drivers

	// one transaction on the input channel; called and returns at a falling edge
	task automatic send_poll(input radio_poll_t p);
		while ($urandom_range(0, 99) < sender_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = p.func;
		packet_present = p.present;
		crc_computed = p.crc_c;
		crc_received = p.crc_r;
		packet_id_bytes = p.id;
		marker_bytes = p.marker;
		id_checksum = p.csum;
		time_now_us = p.now;
		do @(posedge clk); while (in_stall);
		expected_reports.push_back(link_after_item(p));
		@(negedge clk);
	endtask

	// stop sending and wait until every pending result has come back
	task automatic drain_link();
		in_valid = 1'b0;
		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register write; only while the link is drained
	task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [TX_ID_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_STORED_TX_ID: lnk_stored_id = val;
			CFG_BIND_TIMEOUT: lnk_bind_to = val[TIMEOUT_W-1:0];
			CFG_DATA_TIMEOUT: lnk_data_to = val[TIMEOUT_W-1:0];
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	// reset defaults, rejected bind packets, binding, data hops and restarts
	task automatic test_directed_link();
		radio_poll_t p;
		// straight out of reset: bind channel, default 1000 us timeout
		send_poll(quiet_poll(32'd0));
		send_poll(quiet_poll(32'd1001));
		send_poll(restart_item(32'd2000));
		send_poll(quiet_poll(32'd3000));
		send_poll(quiet_poll(32'd3001));
		// bind packets broken one way each
		p = bind_packet(32'hFFFF_FFFF, 32'd3100);
		p.crc_r = p.crc_c ^ 16'h8001;
		send_poll(p);
		p = bind_packet(32'hFFFF_FFFF, 32'd3200);
		p.marker = 24'hFFFFFF;
		send_poll(p);
		p = bind_packet(32'hFFFF_FFFF, 32'd3300);
		p.csum = ~p.csum;
		send_poll(p);
		p = bind_packet(32'hFFFF_FFFF, 32'd3400);
		p.present = 1'b0;
		send_poll(p);
		// good bind with nothing stored: save flag, then data phase
		send_poll(bind_packet(32'hFFFF_FFFF, 32'd3500));
		send_poll(data_packet(32'd3600));
		p = data_packet(32'd3700);
		p.crc_r = ~p.crc_c;
		send_poll(p);
		// a bind packet in the data phase is plain data
		send_poll(bind_packet(32'h0000_0001, 32'd3800));
		send_poll(quiet_poll(32'd8801));
		send_poll(quiet_poll(32'd13802));

		// unbound restart near the top of the time range, bind to ID zero
		drain_link();
		set_register(CFG_STORED_TX_ID, '0);
		send_poll(restart_item(32'hFFFF_FF00));
		send_poll(bind_packet(32'h0000_0000, 32'hFFFF_FF80));
		send_poll(restart_item(32'hFFFF_FFFF));

		// rebind with an ID already stored: no save, stored ID kept
		drain_link();
		set_register(CFG_STORED_TX_ID, 32'h1234_5678);
		set_register(CFG_RESERVED, 32'hFFFF_FFFF);
		send_poll(bind_packet(32'hA5C3_0F81, 32'd500));
		send_poll(restart_item(32'd600));
		send_poll(data_packet(32'd700));
	endtask

	// bind sweep over the whole range and back to the first channel
	task automatic test_bind_sweep();
		drain_link();
		set_register(CFG_STORED_TX_ID, '0);
		set_register(CFG_BIND_TIMEOUT, '0);
		send_poll(restart_item(32'd5000));
		for (int k = 1; k <= 36; k++)
			send_poll(quiet_poll(32'd5000 + k));
	endtask

	// mostly well-formed bind/data sequences with noise and broken packets
	task automatic test_random_traffic(input int gap_pct, input int stall_pct,
			input logic [TX_ID_W-1:0] stored, input logic [TIMEOUT_W-1:0] bind_to,
			input logic [TIMEOUT_W-1:0] data_to);
		radio_poll_t p;
		int pick;
		int span;
		drain_link();
		sender_gap_pct = gap_pct;
		receiver_stall_pct = stall_pct;
		set_register(CFG_STORED_TX_ID, stored);
		set_register(CFG_BIND_TIMEOUT, TX_ID_W'(bind_to));
		set_register(CFG_DATA_TIMEOUT, TX_ID_W'(data_to));
		send_poll(restart_item(clock_us));
		repeat (PHASE_ITEMS) begin
			// time moves around the current timeout, with jumps and wraps
			span = int'(lnk_bound_phase ? lnk_data_to : lnk_bind_to);
			pick = $urandom_range(0, 99);
			if (pick < 3)
				clock_us = $urandom;
			else if (pick < 5)
				clock_us = 32'hFFFF_FFFF - $urandom_range(0, 70000);
			else
				clock_us = clock_us + $urandom_range(0, span + span / 2 + 4);
			pick = $urandom_range(0, 99);
			if (!lnk_bound_phase) begin
				if (pick < 35) begin
					p = bind_packet(($urandom_range(0, 15) == 0) ? '0 : $urandom, clock_us);
				end else if (pick < 50) begin
					p = bind_packet($urandom, clock_us);
					case ($urandom_range(0, 3))
						0: p.crc_r = p.crc_c ^ CRC_W'(1 << $urandom_range(0, 15));
						1: p.marker = p.marker ^ MARKER_W'(1 << $urandom_range(0, 23));
						2: p.csum = p.csum ^ CSUM_W'(1 << $urandom_range(0, 7));
						default: p.present = 1'b0;
					endcase
				end else if (pick < 55) begin
					p = restart_item(clock_us);
				end else begin
					p = noise_poll(clock_us);
				end
			end else begin
				if (pick < 45)
					p = data_packet(clock_us);
				else if (pick < 50)
					p = restart_item(clock_us);
				else
					p = noise_poll(clock_us);
			end
			send_poll(p);
			if ($urandom_range(0, 99) == 0)
				drain_link();
		end
	endtask

	// ---------------------------------------------------------------- checking

	// receiver stalls at random
	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

	// each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS)
					$display("unexpected result: status %0d chan %0d set %0b save %0b id %h",
						status, rf_channel, channel_set, save_id, learned_tx_id);
			end else begin
				want_report = expected_reports.pop_front();
				if (status !== want_report.status || rf_channel !== want_report.chan ||
						channel_set !== want_report.chan_set || save_id !== want_report.save ||
						learned_tx_id !== want_report.id) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS) begin
						$display("mismatch: expected status %0d chan %0d set %0b save %0b id %h",
							want_report.status, want_report.chan, want_report.chan_set,
							want_report.save, want_report.id);
						$display("          got status %0d chan %0d set %0b save %0b id %h",
							status, rf_channel, channel_set, save_id, learned_tx_id);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_STORED_TX_ID;
		cfg_data = '0;
		in_valid = 1'b0;
		func = 1'b0;
		packet_present = 1'b0;
		crc_computed = '0;
		crc_received = '0;
		packet_id_bytes = '0;
		marker_bytes = '0;
		id_checksum = '0;
		time_now_us = '0;
		out_stall = 1'b0;
		n_fail = 0;
		n_cycles = 0;
		clock_us = 32'd20000;
		sender_gap_pct = 13;
		receiver_stall_pct = 74;
		// predictor reset state
		lnk_stored_id = '0;
		lnk_bind_to = BIND_TIMEOUT_RST;
		lnk_data_to = DATA_TIMEOUT_RST;
		lnk_bound_phase = 1'b0;
		lnk_pos = BIND_FIRST_CHANNEL;
		for (int i = 0; i < HOP_SLOTS; i++)
			lnk_hops[i] = '0;
		lnk_last_hop = '0;
		lnk_bound_id = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_link();
		test_bind_sweep();
		test_random_traffic(13, 74, '0, '0, 16'hFFFF);
		test_random_traffic(74, 13, $urandom, 16'hFFFF, '0);
		test_random_traffic(0, 0, $urandom, TIMEOUT_W'($urandom), TIMEOUT_W'($urandom));
		drain_link();

		if (n_fail == 0 && expected_reports.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
